FILE: src/key_click_long_double_detector_unit_defines.svh
// Assertion helpers used by the key detector RTL.
`ifndef KEY_CLICK_LONG_DOUBLE_DETECTOR_UNIT_DEFINES_SVH
`define KEY_CLICK_LONG_DOUBLE_DETECTOR_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define KCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define KCD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/kcd_pkg.sv
package kcd_pkg;

  // Field widths
  localparam int KEY_W     = 4;
  localparam int CODE_W    = 2;
  localparam int CNT_W     = 16;
  localparam int ST_W      = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam int NUM_KEYS_DEF = 16;

  // Key state codes
  localparam logic [ST_W-1:0] ST_IDLE        = 3'd0;
  localparam logic [ST_W-1:0] ST_PRESS_DLY   = 3'd1;
  localparam logic [ST_W-1:0] ST_RELEASE_DLY = 3'd2;
  localparam logic [ST_W-1:0] ST_PRESSED     = 3'd3;
  localparam logic [ST_W-1:0] ST_LONG        = 3'd4;
  localparam logic [ST_W-1:0] ST_DOUBLE      = 3'd5;

  // Event codes
  localparam logic [CODE_W-1:0] EV_CLICK    = 2'd0;
  localparam logic [CODE_W-1:0] EV_LONG     = 2'd1;
  localparam logic [CODE_W-1:0] EV_DOUBLE   = 2'd2;
  localparam logic [CODE_W-1:0] EV_RELEASED = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = 16'd15;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET   = 16'd600;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RESET = 16'd300;

  // One key record as held in the key memory
  typedef struct packed {
    logic [ST_W-1:0]  state;
    logic [ST_W-1:0]  prev;
    logic [CNT_W-1:0] cnt;
  } key_rec_t;

  localparam key_rec_t REC_RESET = '{state: ST_IDLE, prev: ST_IDLE, cnt: '0};

  // Thresholds handed to the transition logic
  typedef struct packed {
    logic [CFG_W-1:0] debounce;
    logic [CFG_W-1:0] long_press;
    logic [CFG_W-1:0] double_click;
  } thresh_t;

  // Event raised by one transition
  typedef struct packed {
    logic              fire;
    logic [CODE_W-1:0] code;
  } key_evt_t;

endpackage

FILE: src/kcd_if.sv
// Tick request channel: one sampled level for one key
interface kcd_tick_if import kcd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_index;
  logic             key_pressed;

  modport source (output valid, key_index, key_pressed, input ready);
  modport sink   (input valid, key_index, key_pressed, output ready);
endinterface

// Event channel: one detected key event
interface kcd_event_if import kcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  event_key;
  logic [CODE_W-1:0] event_code;

  modport source (output valid, event_key, event_code, input ready);
  modport sink   (input valid, event_key, event_code, output ready);
endinterface

FILE: src/key_click_long_double_detector_unit.sv
// Key click / long press / double click detector, one tick request per key sample.
// Throughput: one request per cycle, including back-to-back ticks for the same key,
// while no fired event waits on a full event register. An accepted tick goes through
// the memory read stage, then transition and write-back into the event register.
// Reset: thresholds return to 15/600/300 and all keys read as idle at once through
// per-key valid bits; requests are accepted in the first cycle after reset.
`include "key_click_long_double_detector_unit_defines.svh"

module key_click_long_double_detector_unit import kcd_pkg::*; #(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  kcd_tick_if.sink             tick,
  kcd_event_if.source          evt,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [CFG_W-1:0] debounce_limit;
  logic [CFG_W-1:0] long_press_ticks;
  logic [CFG_W-1:0] double_click_ticks;
  thresh_t          thr;

  logic             accept;
  logic [AW+KEY_W-1:0] key_wide;
  logic [AW-1:0]    rd_addr;
  logic             in_range;

  logic             s1_valid;
  logic [KEY_W-1:0] s1_key;
  logic             s1_down;
  logic             s1_in_range;
  logic [AW+KEY_W-1:0] s1_key_wide;
  logic [AW-1:0]    s1_addr;
  logic             s1_go;
  logic             out_free;
  logic             mem_we;

  key_rec_t         cur_rec;
  key_rec_t         nxt_rec;
  key_evt_t         res;
  logic             fire_eff;

  logic              out_valid;
  logic [KEY_W-1:0]  out_key;
  logic [CODE_W-1:0] out_code;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_limit     <= DEBOUNCE_RESET;
      long_press_ticks   <= LONG_PRESS_RESET;
      double_click_ticks <= DOUBLE_CLICK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE:     debounce_limit     <= cfg_data;
        CFG_LONG_PRESS:   long_press_ticks   <= cfg_data;
        CFG_DOUBLE_CLICK: double_click_ticks <= cfg_data;
        default:          ;
      endcase
    end
  end

  assign thr = '{debounce: debounce_limit, long_press: long_press_ticks,
                 double_click: double_click_ticks};

  // Address decode for the incoming request
  assign key_wide = {{AW{1'b0}}, tick.key_index};
  assign rd_addr  = key_wide[AW-1:0];
  assign in_range = ({{(32-KEY_W){1'b0}}, tick.key_index} < 32'(NUM_KEYS));

  // Handshake: stage 1 drains when its event (if any) has a slot
  assign out_free   = !out_valid || evt.ready;
  assign fire_eff   = s1_in_range && res.fire;
  assign s1_go      = s1_valid && (!fire_eff || out_free);
  assign tick.ready = !s1_valid || s1_go;
  assign accept     = tick.valid && tick.ready;

  // Stage 1: request waiting on its record
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key      <= tick.key_index;
      s1_down     <= tick.key_pressed;
      s1_in_range <= in_range;
    end
  end

  assign s1_key_wide = {{AW{1'b0}}, s1_key};
  assign s1_addr     = s1_key_wide[AW-1:0];
  assign mem_we      = s1_go && s1_in_range;

  kcd_key_mem #(
    .NUM_KEYS (NUM_KEYS),
    .AW       (AW)
  ) u_key_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .wr_en   (mem_we),
    .wr_addr (s1_addr),
    .wr_data (nxt_rec),
    .rd_rec  (cur_rec)
  );

  kcd_fsm u_fsm (
    .cur  (cur_rec),
    .down (s1_down),
    .thr  (thr),
    .nxt  (nxt_rec),
    .evt  (res)
  );

  // Event register: load on a fired transition, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && fire_eff) begin
      out_valid <= 1'b1;
    end else if (evt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && fire_eff) begin
      out_key  <= s1_key;
      out_code <= res.code;
    end
  end

  assign evt.valid      = out_valid;
  assign evt.event_key  = out_key;
  assign evt.event_code = out_code;

  `KCD_ASSERT(a_stall_hold, (s1_valid && !s1_go) |-> !tick.ready, "request taken in stall")
  `KCD_ASSERT(a_range_write, (s1_valid && !s1_in_range) |-> !mem_we, "out-of-range key written")
  `KCD_ASSERT(a_event_src, $rose(out_valid) |-> $past(s1_valid && fire_eff), "stray event")
  `KCD_ASSERT_ALWAYS(a_reset_clears_event, $past(rst) |-> !out_valid, "event valid after reset")

endmodule

FILE: src/kcd_key_mem.sv
module kcd_key_mem import kcd_pkg::*; #(
  parameter int NUM_KEYS = NUM_KEYS_DEF,
  parameter int AW       = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  key_rec_t      wr_data,
  output key_rec_t      rd_rec
);

  key_rec_t            mem [NUM_KEYS];
  key_rec_t            rd_data;
  logic [NUM_KEYS-1:0] vld;
  logic                rd_vld;
  logic                fwd;
  key_rec_t            fwd_data;

  // Write and read the record store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Mark entries written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Capture entry validity and a same-cycle write to the entry being read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      fwd    <= 1'b0;
    end else if (rd_en) begin
      rd_vld <= vld[rd_addr];
      fwd    <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data <= wr_data;
    end
  end

  // Resolve: forwarded write, then stored entry, then reset value
  always_comb begin
    if (fwd) begin
      rd_rec = fwd_data;
    end else if (rd_vld) begin
      rd_rec = rd_data;
    end else begin
      rd_rec = REC_RESET;
    end
  end

endmodule

FILE: src/kcd_fsm.sv
module kcd_fsm import kcd_pkg::*; (
  input  key_rec_t cur,
  input  logic     down,
  input  thresh_t  thr,
  output key_rec_t nxt,
  output key_evt_t evt
);

  logic [ST_W-1:0]   nstate;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_inc;
  logic              fire;
  logic [CODE_W-1:0] code;

  assign cnt_inc = cur.cnt + 16'd1;

  // Advance one key by one tick
  always_comb begin
    nstate = cur.state;
    cnt    = cur.cnt;
    fire   = 1'b0;
    code   = EV_CLICK;
    case (cur.state)
      ST_IDLE: begin
        if (down) begin
          nstate = ST_PRESS_DLY;
          cnt    = '0;
        end
      end
      ST_PRESS_DLY: begin
        cnt = cnt_inc;
        if (cnt_inc >= thr.debounce) begin
          cnt = '0;
          if (!down) begin
            nstate = cur.prev;
          end else if (cur.prev == ST_IDLE) begin
            nstate = ST_PRESSED;
          end else if (cur.prev == ST_DOUBLE) begin
            nstate = ST_LONG;
            fire   = 1'b1;
            code   = EV_DOUBLE;
          end else begin
            nstate = ST_IDLE;
          end
        end
      end
      ST_RELEASE_DLY: begin
        cnt = cnt_inc;
        if (cnt_inc >= thr.debounce) begin
          cnt = '0;
          if (down) begin
            nstate = cur.prev;
          end else if (cur.prev == ST_PRESSED) begin
            nstate = ST_DOUBLE;
          end else if (cur.prev == ST_LONG) begin
            nstate = ST_IDLE;
            fire   = 1'b1;
            code   = EV_RELEASED;
          end else begin
            nstate = ST_IDLE;
          end
        end
      end
      ST_PRESSED: begin
        if (!down) begin
          nstate = ST_RELEASE_DLY;
          cnt    = '0;
        end else begin
          cnt = cnt_inc;
          if (cnt_inc >= thr.long_press) begin
            nstate = ST_LONG;
            fire   = 1'b1;
            code   = EV_LONG;
          end
        end
      end
      ST_LONG: begin
        if (!down) begin
          nstate = ST_RELEASE_DLY;
          cnt    = '0;
        end
      end
      ST_DOUBLE: begin
        if (down) begin
          nstate = ST_PRESS_DLY;
          cnt    = '0;
        end else begin
          cnt = cnt_inc;
          if (cnt_inc >= thr.double_click) begin
            nstate = ST_LONG;
            fire   = 1'b1;
            code   = EV_CLICK;
          end
        end
      end
      default: begin
        nstate = ST_IDLE;
      end
    endcase
  end

  // Record previous state and raise the event only on a state change
  always_comb begin
    nxt.cnt   = cnt;
    nxt.state = cur.state;
    nxt.prev  = cur.prev;
    evt.fire  = 1'b0;
    evt.code  = code;
    if (nstate != cur.state) begin
      nxt.state = nstate;
      nxt.prev  = cur.state;
      evt.fire  = fire;
    end
  end

endmodule
